>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the RTL. Every module that uses them has
// its clock named clk and its asynchronous active-low reset named arst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ilp_pkg.sv
// ---------------------------------------------------------------------------
// ilp_pkg
// Types, character codes and limits for the integer literal parser.
// ---------------------------------------------------------------------------
package ilp_pkg;

	// Parser phase
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_SIGN = 3'd1,
		PH_SDEC = 3'd2,
		PH_DEC  = 3'd3,
		PH_ZERO = 3'd4,
		PH_BIN  = 3'd5,
		PH_HEX  = 3'd6
	} phase_t;

	// Result status
	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_NONE = 2'd1,
		STATUS_OVF  = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_stream;
	} item_t;

	typedef struct packed {
		logic signed [31:0] parsed_value;
		logic [6:0]         parsed_length;
		status_t            parse_status;
		logic               char_consumed;
	} result_t;

	// Character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LO_B  = 8'h62;
	localparam logic [7:0] CH_UP_B  = 8'h42;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;

	// Limits
	localparam logic [6:0] DEC_COUNT_CAP       = 7'd65;
	localparam logic [6:0] BIN_DIGITS_MAX      = 7'd32;
	localparam logic [6:0] HEX_DIGITS_MAX      = 7'd8;
	localparam logic [6:0] MAX_PREFIXED_RESET  = 7'd64;

endpackage

>>> rtl/ilp_ifs.sv
// ---------------------------------------------------------------------------
// ilp_ifs
// Valid/ready channels for characters in and parse results out.
// ---------------------------------------------------------------------------
interface ilp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_stream;

	modport source (output valid, output char_in, output end_of_stream, input ready);
	modport sink   (input valid, input char_in, input end_of_stream, output ready);
endinterface

interface ilp_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] parsed_value;
	logic [6:0]         parsed_length;
	logic [1:0]         parse_status;
	logic               char_consumed;

	modport source (output valid, output parsed_value, output parsed_length,
		output parse_status, output char_consumed, input ready);
	modport sink   (input valid, input parsed_value, input parsed_length,
		input parse_status, input char_consumed, output ready);
endinterface

>>> rtl/integer_literal_parser.sv
// ---------------------------------------------------------------------------
// integer_literal_parser
// Streaming parser for one signed 32-bit integer literal: decimal with an
// optional sign, hex after 0x, binary after 0b.
// ---------------------------------------------------------------------------
//
//   channel   | dir | transaction
//   ----------+-----+--------------------------------------------------
//   chars     | in  | one character (char_in) or end-of-stream mark
//   results   | out | value, length, status, consumed flag
//   cfg_wr_*  | in  | write of max_prefixed_digits (7 bits)
//
// One character transaction per cycle while results are taken. A character is
// captured in the input register and parsed from there; a result it causes is
// loaded into the result register by the parse step that raises it.
// Reset clears the parser to idle and sets the digit limit to 64.
// While the result register holds a result the sink has not taken, the
// parse step stalls, and chars.ready drops once the input register is full.
//
module integer_literal_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [6:0]    cfg_wr_data,
	ilp_char_if.sink      chars,
	ilp_result_if.source  results
);

	logic               item_valid;
	ilp_pkg::item_t     item;
	logic               out_free;
	logic               advance;
	logic               res_valid;
	ilp_pkg::result_t   res;

	// Parse the held character only when a result it may raise has a place to go.
	assign advance = item_valid && out_free;

	ilp_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars),
		.advance (advance),
		.valid   (item_valid),
		.item    (item)
	);

	// Parser state machine and digit limit register
	ilp_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (advance),
		.item        (item),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Result register toward the sink
	ilp_out_stage u_out_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (res_valid),
		.res     (res),
		.free    (out_free),
		.results (results)
	);

endmodule

>>> rtl/ilp_in_stage.sv
// ---------------------------------------------------------------------------
// ilp_in_stage
// Input register: capture one character transaction, hold it until parsed.
// ---------------------------------------------------------------------------
module ilp_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	ilp_char_if.sink             chars,
	input  logic                 advance,
	output logic                 valid,
	output ilp_pkg::item_t       item
);

	logic           valid_s1;
	ilp_pkg::item_t item_s1;

	// Refill in the same cycle the held item moves on.
	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			item_s1.char_in       <= chars.char_in;
			item_s1.end_of_stream <= chars.end_of_stream;
		end
	end

	assign valid = valid_s1;
	assign item  = item_s1;

endmodule

>>> rtl/ilp_parse.sv
// ---------------------------------------------------------------------------
// ilp_parse
// Parser state and per-character next-state logic; raises a result when a
// literal ends. Also holds the prefixed digit limit register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ilp_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [6:0]           cfg_wr_data,
	input  logic                 step,
	input  ilp_pkg::item_t       item,
	output logic                 res_valid,
	output ilp_pkg::result_t     res
);

	ilp_pkg::phase_t phase_q, phase_d;
	logic [30:0]     acc_q, acc_d;
	logic [6:0]      count_q, count_d;
	logic            neg_q, neg_d;
	logic [6:0]      max_digits_q;

	logic        emit;
	logic [7:0]  c;
	logic        eos;
	logic        is_dec;
	logic        is_hex_letter;
	logic        is_bin;
	logic [3:0]  hex_val;
	logic [34:0] dec_sum;
	logic        dec_ovf;
	logic [6:0]  base_lim;
	logic [6:0]  lim;
	logic        pfx_ovf;
	logic [31:0] mag;
	logic [31:0] ok_value;

	// Prefixed digit limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_digits_q <= ilp_pkg::MAX_PREFIXED_RESET;
		end else if (cfg_wr_en) begin
			max_digits_q <= cfg_wr_data;
		end
	end

	assign c   = item.char_in;
	assign eos = item.end_of_stream;

	assign is_dec = !eos && (c >= ilp_pkg::CH_ZERO) && (c <= ilp_pkg::CH_NINE);
	assign is_hex_letter = !eos &&
		(((c >= ilp_pkg::CH_LO_A) && (c <= ilp_pkg::CH_LO_F)) ||
		 ((c >= ilp_pkg::CH_UP_A) && (c <= ilp_pkg::CH_UP_F)));
	assign is_bin = !eos && ((c == ilp_pkg::CH_ZERO) || (c == ilp_pkg::CH_ONE));
	// Low nibble is the digit for 0-9; letters a-f and A-F sit 9 below their value.
	assign hex_val = is_dec ? c[3:0] : 4'(c[3:0] + 4'd9);

	// acc * 10 + d, overflow when above 2^31-1
	assign dec_sum = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {31'd0, c[3:0]};
	assign dec_ovf = (dec_sum[34:31] != 4'd0) || (count_q >= ilp_pkg::DEC_COUNT_CAP);

	assign base_lim = (phase_q == ilp_pkg::PH_BIN) ? ilp_pkg::BIN_DIGITS_MAX
	                                                : ilp_pkg::HEX_DIGITS_MAX;
	assign lim = (max_digits_q < base_lim) ? max_digits_q : base_lim;
	assign pfx_ovf = (count_q >= lim) ||
		((phase_q == ilp_pkg::PH_BIN) ? acc_q[30] : (acc_q[30:27] != 4'd0));

	assign mag      = {1'b0, acc_q};
	assign ok_value = neg_q ? 32'(-mag) : mag;

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		count_d = count_q;
		neg_d   = neg_q;
		emit    = 1'b0;
		res.parsed_value  = '0;
		res.parsed_length = '0;
		res.parse_status  = ilp_pkg::STATUS_NONE;
		res.char_consumed = 1'b0;

		case (phase_q)
			ilp_pkg::PH_SIGN,
			ilp_pkg::PH_SDEC,
			ilp_pkg::PH_DEC: begin
				if (!is_dec) begin
					emit = 1'b1;
					if (phase_q != ilp_pkg::PH_SIGN) begin
						res.parsed_value  = $signed(ok_value);
						res.parsed_length = count_q;
						res.parse_status  = ilp_pkg::STATUS_OK;
					end
				end else if (dec_ovf) begin
					emit = 1'b1;
					res.parse_status = ilp_pkg::STATUS_OVF;
				end else begin
					phase_d = (phase_q == ilp_pkg::PH_SIGN) ? ilp_pkg::PH_SDEC : phase_q;
					acc_d   = dec_sum[30:0];
					count_d = 7'(count_q + 7'd1);
				end
			end
			ilp_pkg::PH_ZERO: begin
				if (!eos && ((c == ilp_pkg::CH_LO_B) || (c == ilp_pkg::CH_UP_B))) begin
					phase_d = ilp_pkg::PH_BIN;
					acc_d   = '0;
					count_d = '0;
				end else if (!eos && ((c == ilp_pkg::CH_LO_X) || (c == ilp_pkg::CH_UP_X))) begin
					phase_d = ilp_pkg::PH_HEX;
					acc_d   = '0;
					count_d = '0;
				end else begin
					// Lone zero
					emit = 1'b1;
					res.parsed_length = 7'd1;
					res.parse_status  = ilp_pkg::STATUS_OK;
				end
			end
			ilp_pkg::PH_BIN,
			ilp_pkg::PH_HEX: begin
				if ((phase_q == ilp_pkg::PH_BIN) ? !is_bin : !(is_dec || is_hex_letter)) begin
					emit = 1'b1;
					if (count_q != 7'd0) begin
						res.parsed_value  = $signed(ok_value);
						res.parsed_length = count_q;
						res.parse_status  = ilp_pkg::STATUS_OK;
					end
				end else if (pfx_ovf) begin
					emit = 1'b1;
					res.parse_status = ilp_pkg::STATUS_OVF;
				end else begin
					acc_d = (phase_q == ilp_pkg::PH_BIN) ? {acc_q[29:0], c[0]}
					                                      : {acc_q[26:0], hex_val};
					count_d = 7'(count_q + 7'd1);
				end
			end
			default: begin
				// Idle: look for a sign, a leading zero or a first digit.
				acc_d   = '0;
				count_d = '0;
				neg_d   = 1'b0;
				phase_d = ilp_pkg::PH_IDLE;
				if (eos) begin
					emit = 1'b1;
				end else if ((c == ilp_pkg::CH_PLUS) || (c == ilp_pkg::CH_MINUS)) begin
					phase_d = ilp_pkg::PH_SIGN;
					neg_d   = (c == ilp_pkg::CH_MINUS);
					count_d = 7'd1;
				end else if (c == ilp_pkg::CH_ZERO) begin
					phase_d = ilp_pkg::PH_ZERO;
				end else if (is_dec) begin
					phase_d = ilp_pkg::PH_DEC;
					acc_d   = {27'd0, c[3:0]};
					count_d = 7'd1;
				end else begin
					emit = 1'b1;
				end
			end
		endcase

		// Every result ends the literal: drop back to idle.
		if (emit) begin
			phase_d = ilp_pkg::PH_IDLE;
			acc_d   = '0;
			count_d = '0;
			neg_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ilp_pkg::PH_IDLE;
			acc_q   <= '0;
			count_q <= '0;
			neg_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			count_q <= count_d;
			neg_q   <= neg_d;
		end
	end

	assign res_valid = step && emit;

	`ASSERT_NEXT(a_emit_to_idle, res_valid, phase_q == ilp_pkg::PH_IDLE,
		"parser not idle after a result")
	`ASSERT_ALWAYS(a_fail_is_zero,
		!res_valid || (res.parse_status == ilp_pkg::STATUS_OK) ||
		((res.parsed_value == 32'sd0) && (res.parsed_length == 7'd0)),
		"failed result carries a value or length")
	`ASSERT_ALWAYS(a_dec_count_cap, count_q <= ilp_pkg::DEC_COUNT_CAP,
		"digit count beyond decimal cap")
	`ASSERT_ALWAYS(a_hex_count_cap,
		(phase_q != ilp_pkg::PH_HEX) || (count_q <= ilp_pkg::HEX_DIGITS_MAX),
		"hex digit count beyond eight")

endmodule

>>> rtl/ilp_out_stage.sv
// ---------------------------------------------------------------------------
// ilp_out_stage
// Result register: hold one result transaction until the sink takes it.
// ---------------------------------------------------------------------------
module ilp_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  ilp_pkg::result_t     res,
	output logic                 free,
	ilp_result_if.source         results
);

	logic             valid_s2;
	ilp_pkg::result_t res_s2;

	assign free = !valid_s2 || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

	assign results.valid         = valid_s2;
	assign results.parsed_value  = res_s2.parsed_value;
	assign results.parsed_length = res_s2.parsed_length;
	assign results.parse_status  = res_s2.parse_status;
	assign results.char_consumed = res_s2.char_consumed;

endmodule

>>> tb/ilp_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ilp_tb_pkg
// Literal predictor and parse scoreboard for the integer literal parser
// bench. It keeps its own copy of the parser state and the digit cap and
// queues one expected parse for each character that ends a literal.
// ----------------------------------------------------------------------------
package ilp_tb_pkg;
	import ilp_pkg::*;

	localparam int unsigned MAG_MAX      = 32'h7FFF_FFFF;
	localparam int          REPORT_LIMIT = 10;

	class literal_scoreboard;
		phase_t      phase;
		logic [30:0] acc;
		logic [6:0]  count;
		logic        neg;
		logic [6:0]  digit_cap;
		result_t     expected_parses[$];
		int          mismatches;
		int          chars_seen;
		int          eos_seen;
		int          status_seen[3];

		function new();
			digit_cap = MAX_PREFIXED_RESET;
			mismatches = 0;
			chars_seen = 0;
			eos_seen = 0;
			status_seen = '{0, 0, 0};
			clear_parse();
		endfunction

		function void clear_parse();
			phase = PH_IDLE;
			acc = '0;
			count = '0;
			neg = 1'b0;
		endfunction

		function void set_digit_cap(input logic [6:0] cap);
			digit_cap = cap;
		endfunction

		// Fill in a parse and drop back to idle.
		function bit finish_parse(output result_t r, input logic signed [31:0] v,
				input logic [6:0] len, input status_t st);
			r.parsed_value = v;
			r.parsed_length = len;
			r.parse_status = st;
			r.char_consumed = 1'b0;
			clear_parse();
			return 1'b1;
		endfunction

		function bit finish_ok(output result_t r);
			logic signed [31:0] v;
			v = {1'b0, acc};
			if (neg)
				v = -v;
			return finish_parse(r, v, count, STATUS_OK);
		endfunction

		function bit dec_digit(output result_t r, input int unsigned d);
			if (count >= DEC_COUNT_CAP)
				return finish_parse(r, 32'sd0, 7'd0, STATUS_OVF);
			if (int'(acc) > (MAG_MAX - d) / 10)
				return finish_parse(r, 32'sd0, 7'd0, STATUS_OVF);
			acc = 31'(acc * 10 + d);
			count++;
			return 1'b0;
		endfunction

		// Advance the parser by one character; return 1 when a parse comes out.
		function bit parse_step(input logic [7:0] c, input logic eos, output result_t r);
			bit          is_digit;
			int          d;
			logic [6:0]  lim;
			int unsigned a;
			is_digit = !eos && c >= CH_ZERO && c <= CH_NINE;
			a = acc;
			r = '0;
			case (phase)
				PH_SIGN: begin
					if (!is_digit)
						return finish_parse(r, 32'sd0, 7'd0, STATUS_NONE);
					phase = PH_SDEC;
					return dec_digit(r, c - CH_ZERO);
				end
				PH_SDEC, PH_DEC: begin
					if (!is_digit)
						return finish_ok(r);
					return dec_digit(r, c - CH_ZERO);
				end
				PH_ZERO: begin
					if (!eos && (c == CH_LO_B || c == CH_UP_B)) begin
						phase = PH_BIN;
						acc = '0;
						count = '0;
						return 1'b0;
					end
					if (!eos && (c == CH_LO_X || c == CH_UP_X)) begin
						phase = PH_HEX;
						acc = '0;
						count = '0;
						return 1'b0;
					end
					return finish_parse(r, 32'sd0, 7'd1, STATUS_OK);
				end
				PH_BIN, PH_HEX: begin
					d = -1;
					if (!eos) begin
						if (phase == PH_BIN) begin
							if (c == CH_ZERO || c == CH_ONE)
								d = c - CH_ZERO;
						end else if (c >= CH_ZERO && c <= CH_NINE)
							d = c - CH_ZERO;
						else if (c >= CH_LO_A && c <= CH_LO_F)
							d = c - CH_LO_A + 10;
						else if (c >= CH_UP_A && c <= CH_UP_F)
							d = c - CH_UP_A + 10;
					end
					if (d < 0) begin
						if (count == 0)
							return finish_parse(r, 32'sd0, 7'd0, STATUS_NONE);
						return finish_ok(r);
					end
					lim = (phase == PH_BIN) ? BIN_DIGITS_MAX : HEX_DIGITS_MAX;
					if (digit_cap < lim)
						lim = digit_cap;
					if (count >= lim)
						return finish_parse(r, 32'sd0, 7'd0, STATUS_OVF);
					if (phase == PH_BIN) begin
						if (a > MAG_MAX / 2)
							return finish_parse(r, 32'sd0, 7'd0, STATUS_OVF);
						acc = 31'(a * 2 + d);
					end else begin
						if (a > MAG_MAX / 16)
							return finish_parse(r, 32'sd0, 7'd0, STATUS_OVF);
						acc = 31'(a * 16 + d);
					end
					count++;
					return 1'b0;
				end
				default: begin
					clear_parse();
					if (eos)
						return finish_parse(r, 32'sd0, 7'd0, STATUS_NONE);
					if (c == CH_PLUS || c == CH_MINUS) begin
						phase = PH_SIGN;
						neg = (c == CH_MINUS);
						count = 7'd1;
						return 1'b0;
					end
					if (c == CH_ZERO) begin
						phase = PH_ZERO;
						return 1'b0;
					end
					if (is_digit) begin
						phase = PH_DEC;
						acc = 31'(c - CH_ZERO);
						count = 7'd1;
						return 1'b0;
					end
					return finish_parse(r, 32'sd0, 7'd0, STATUS_NONE);
				end
			endcase
		endfunction

		function void note_char(input logic [7:0] c, input logic eos);
			result_t r;
			chars_seen++;
			if (eos)
				eos_seen++;
			if (parse_step(c, eos, r))
				expected_parses.push_back(r);
		endfunction

		function void complain(input string msg);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("[%0t] MISMATCH %s", $time, msg);
		endfunction

		function void check_result(input logic signed [31:0] v, input logic [6:0] len,
				input logic [1:0] st, input logic consumed);
			result_t want;
			if (expected_parses.size() == 0) begin
				complain($sformatf("unexpected parse: value %0d length %0d status %0d",
					v, len, st));
				return;
			end
			want = expected_parses.pop_front();
			status_seen[int'(want.parse_status)]++;
			if (v !== want.parsed_value || len !== want.parsed_length ||
					st !== want.parse_status || consumed !== want.char_consumed)
				complain($sformatf({"expected value %0d length %0d status %0d consumed %0b,",
					" got value %0d length %0d status %0d consumed %0b"},
					want.parsed_value, want.parsed_length, want.parse_status,
					want.char_consumed, v, len, st, consumed));
		endfunction

		function int pending();
			return expected_parses.size();
		endfunction

		function void close_out();
			if (expected_parses.size() != 0)
				complain($sformatf("%0d expected parses never came out",
					expected_parses.size()));
		endfunction
	endclass

endpackage

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - integer literal parser bench
// Feeds character streams to the parser: a short directed set of literals,
// then random decimal, hex, binary and noise sequences under several digit
// caps, with random gaps on both channels, a long result hold-off and
// a sender pause. Every parse that comes out is checked against a predictor.
// ----------------------------------------------------------------------------
module tb;
	import ilp_pkg::*;
	import ilp_tb_pkg::*;

	localparam int RESET_CYCLES      = 12;
	localparam int SINK_HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT        = 5000;
	localparam int SETTLE_CYCLES     = 4;
	localparam int CHARS_PER_SETTING = 200;
	localparam int NUM_SETTINGS      = 8;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [6:0] cfg_wr_data;

	ilp_char_if   chars_if();
	ilp_result_if results_if();

	integer_literal_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.chars       (chars_if),
		.results     (results_if)
	);

	literal_scoreboard parses;

	// Idling controls, changed per stretch by the stimulus process.
	bit src_gaps;
	bit sink_stalls;
	bit hold_sink;
	int holds_done;
	int idle_cycles;

	string hex_chars = "0123456789abcdefABCDEF";
	string sep_chars = " ,;)+-\n";

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly back to back, sometimes a short gap, rarely a long gap.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one character transaction and hold it until the parser takes it.
	// Valid is left high on acceptance so that a back-to-back transaction
	// never lowers and raises it in the same time step.
	task automatic send_char(input logic [7:0] c, input logic eos);
		int gap;
		gap = src_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.char_in <= c;
		chars_if.end_of_stream <= eos;
		do @(posedge clk); while (!chars_if.ready);
		parses.note_char(c, eos);
	endtask

	task automatic send_text(input string s, input bit eos_after);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
		if (eos_after)
			send_char(8'($urandom), 1'b1);
	endtask

	// Drop valid, wait for every outstanding parse, then let the pipe settle
	// in case the last character started a literal that has no parse yet.
	task automatic drain_parses();
		chars_if.valid <= 1'b0;
		while (parses.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_digit_cap(input logic [6:0] cap);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		parses.set_digit_cap(cap);
	endtask

	// One random literal (or noise) followed by a terminator.
	task automatic send_literal();
		int kind;
		int pick;
		int n;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2, 3: begin
				// decimal, signed for kinds 2 and 3
				if (kind >= 2)
					send_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS, 1'b0);
				pick = $urandom_range(0, 9);
				if (pick < 2) begin
					// straddle the 2^31-1 bound
					send_text($sformatf("%0d", 32'd2147483590 + $urandom_range(0, 70)), 1'b0);
				end else if (pick < 3) begin
					// zero padding of lengths around the decimal digit count cap
					repeat ($urandom_range(60, 66)) send_char(CH_ZERO, 1'b0);
					send_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
				end else begin
					n = (pick < 4) ? $urandom_range(11, 13) : $urandom_range(1, 9);
					send_char(8'(CH_ZERO + $urandom_range(1, 9)), 1'b0);
					repeat (n - 1) send_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
				end
			end
			4, 5: begin
				send_char(CH_ZERO, 1'b0);
				send_char($urandom_range(0, 1) ? CH_UP_X : CH_LO_X, 1'b0);
				repeat ($urandom_range(0, 9))
					send_char(hex_chars[$urandom_range(0, hex_chars.len() - 1)], 1'b0);
			end
			6, 7: begin
				send_char(CH_ZERO, 1'b0);
				send_char($urandom_range(0, 1) ? CH_UP_B : CH_LO_B, 1'b0);
				n = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(28, 34);
				repeat (n) send_char(8'(CH_ZERO + $urandom_range(0, 1)), 1'b0);
			end
			8: send_char(CH_ZERO, 1'b0);
			default: repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0);
		endcase
		// terminator: end of stream, a separator, or any byte at all
		pick = $urandom_range(0, 19);
		if (pick < 9)
			send_char(8'($urandom), 1'b1);
		else if (pick < 15)
			send_char(sep_chars[$urandom_range(0, sep_chars.len() - 1)], 1'b0);
		else
			send_char(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// Result side: ready high, random stalls, and a long hold-off on request.
	initial begin : result_sink
		results_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_sink) begin
				hold_sink = 1'b0;
				results_if.ready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(posedge clk);
			end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
				results_if.ready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end else begin
				results_if.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Check every parse transaction against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && results_if.valid && results_if.ready)
			parses.check_result(results_if.parsed_value, results_if.parsed_length,
				results_if.parse_status, results_if.char_consumed);
	end

	// Watchdog: end the run if no transaction moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (chars_if.valid && chars_if.ready) ||
				(results_if.valid && results_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: %0d cycles without a transaction", idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [6:0] cap;
		int start;
		parses = new();
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		hold_sink = 1'b0;
		holds_done = 0;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		chars_if.valid <= 1'b0;
		chars_if.char_in <= '0;
		chars_if.end_of_stream <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed literals under the reset digit cap.
		send_char(8'($urandom), 1'b1);  // end of stream with nothing parsed
		send_char(8'hFF, 1'b0);         // bad first character, top byte
		send_char(8'h00, 1'b0);         // bad first character, bottom byte
		send_text("-", 1'b1);           // sign without digits
		send_text("0x", 1'b1);          // prefix without digits
		send_text("0", 1'b1);           // lone zero at end of stream
		send_text("0Z", 1'b0);          // lone zero ended by a letter
		send_text("+5a", 1'b0);         // signed decimal, terminator not taken
		send_text("0B1", 1'b1);         // binary
		send_text("0XfA", 1'b1);        // hex with mixed case
		drain_parses();

		// Random literals under a series of digit caps, extremes included.
		for (int k = 0; k < NUM_SETTINGS; k++) begin
			case (k)
				0: cap = 7'd1;
				1: cap = 7'd64;
				2: cap = 7'd8;
				3: cap = 7'd32;
				NUM_SETTINGS - 1: cap = MAX_PREFIXED_RESET;
				default: cap = 7'($urandom_range(2, 63));
			endcase
			set_digit_cap(cap);
			// stretch 1 runs with no idling at all
			src_gaps = (k != 1) && ($urandom_range(0, 3) != 0);
			sink_stalls = (k != 1) && ($urandom_range(0, 3) != 0);

			if (k == 3) begin
				// Hold off the result side and keep pushing characters
				// that each give a parse, so the parser backs up.
				hold_sink = 1'b1;
				holds_done++;
				while (hold_sink)
					@(posedge clk);
				src_gaps = 1'b0;
				repeat (30) send_char(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
				// then pause the sender until every parse is out
				drain_parses();
				src_gaps = 1'b1;
			end

			start = parses.chars_seen;
			while (parses.chars_seen - start < CHARS_PER_SETTING) begin
				send_literal();
				if ($urandom_range(0, 49) == 0)
					drain_parses();
			end
			drain_parses();
		end

		repeat (10) @(posedge clk);
		parses.close_out();
		$display({"covered %0d characters (%0d end-of-stream marks), parses:",
			" %0d ok, %0d no number, %0d overflow"},
			parses.chars_seen, parses.eos_seen, parses.status_seen[0],
			parses.status_seen[1], parses.status_seen[2]);
		$display({"%0d digit cap settings from 1 to 64,",
			" %0d long result hold-off(s), %0d mismatches"},
			NUM_SETTINGS, holds_done, parses.mismatches);
		if (parses.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/ilp_pkg.sv
rtl/ilp_ifs.sv
rtl/ilp_in_stage.sv
rtl/ilp_parse.sv
rtl/ilp_out_stage.sv
rtl/integer_literal_parser.sv
tb/ilp_tb_pkg.sv
tb/tb.sv
